// ===== design/ahpc_pkg.sv =====
`default_nettype none
package ahpc_pkg;

  // Block averaging
  localparam int SAMPLES   = 10;
  localparam int ADC_W     = 16;
  localparam int ADC_LSB   = 4;
  localparam int VAL_W     = 12;
  localparam int VAL_MAX   = 4095;
  localparam int SUM_W     = $clog2(SAMPLES * VAL_MAX + 1);
  localparam int CNT_W     = $clog2(SAMPLES + 1);

  // Divide by SAMPLES as multiply by rounded-up reciprocal, exact for any SUM_W-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int MULT_W    = SUM_W + 1;
  localparam int PROD_W    = SUM_W + MULT_W;

  // Request kinds
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COMMAND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  // Commands
  localparam int CMD_W = 8;
  localparam logic [CMD_W-1:0] CMD_STOP   = 8'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE = 8'd1;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_THRESH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESH = 1'd1;
  localparam logic [VAL_W-1:0] ON_THRESH_RST  = 12'd3500;
  localparam logic [VAL_W-1:0] OFF_THRESH_RST = 12'd2000;

  typedef struct packed {
    logic tick;
    logic stop;
    logic enable;
  } ctl_step_t;

  typedef struct packed {
    logic pump_on;
    logic enabled;
  } ctl_stat_t;

endpackage
`default_nettype wire

// ===== design/ahpc_avg.sv =====
`default_nettype none
module ahpc_avg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        sample_en,
  input  wire logic [ahpc_pkg::VAL_W-1:0]  sample_val,
  output logic      [ahpc_pkg::VAL_W-1:0]  block_mean
);
  import ahpc_pkg::*;

  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]  count_r, count_nxt, count_inc;
  logic [VAL_W-1:0]  mean_r, mean_nxt;
  logic [PROD_W-1:0] prod;
  logic              block_full;

  assign sum_add    = sum_r + SUM_W'(sample_val);
  assign count_inc  = count_r + 1'b1;
  assign block_full = (count_inc == CNT_W'(SAMPLES));
  assign prod       = PROD_W'(sum_add) * PROD_W'(DIV_MULT);

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    mean_nxt  = mean_r;
    if (sample_en) begin
      if (block_full) begin
        mean_nxt  = prod[DIV_SHIFT +: VAL_W];
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
      mean_r  <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      mean_r  <= mean_nxt;
    end
  end

  assign block_mean = mean_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(SAMPLES))
    else $error("sample count out of range");
  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    sample_en && block_full |=> sum_r == '0 && count_r == '0)
    else $error("block wrap did not clear sum");

endmodule
`default_nettype wire

// ===== design/ahpc_ctl.sv =====
`default_nettype none
module ahpc_ctl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ahpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ahpc_pkg::VAL_W-1:0]    cfg_wdata,
  input  wire ahpc_pkg::ctl_step_t           step,
  input  wire logic [ahpc_pkg::VAL_W-1:0]    mean,
  output ahpc_pkg::ctl_stat_t                stat
);
  import ahpc_pkg::*;

  logic [VAL_W-1:0] on_thresh_r, on_thresh_nxt;
  logic [VAL_W-1:0] off_thresh_r, off_thresh_nxt;
  logic             enable_r, enable_nxt;
  logic             pump_r, pump_nxt;

  always_comb begin
    on_thresh_nxt  = on_thresh_r;
    off_thresh_nxt = off_thresh_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ON_THRESH:  on_thresh_nxt  = cfg_wdata;
        REG_OFF_THRESH: off_thresh_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    enable_nxt = enable_r;
    pump_nxt   = pump_r;
    if (step.stop) begin
      enable_nxt = 1'b0;
      pump_nxt   = 1'b0;
    end else if (step.enable) begin
      enable_nxt = 1'b1;
    end else if (step.tick && enable_r) begin
      // turn-on wins when thresholds are crossed
      if (mean > on_thresh_r)
        pump_nxt = 1'b1;
      else if (mean < off_thresh_r)
        pump_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thresh_r  <= ON_THRESH_RST;
      off_thresh_r <= OFF_THRESH_RST;
      enable_r     <= 1'b1;
      pump_r       <= 1'b0;
    end else begin
      on_thresh_r  <= on_thresh_nxt;
      off_thresh_r <= off_thresh_nxt;
      enable_r     <= enable_nxt;
      pump_r       <= pump_nxt;
    end
  end

  assign stat.pump_on = pump_nxt;
  assign stat.enabled = enable_nxt;

  a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
    !enable_r |-> !pump_r)
    else $error("pump running with control disabled");
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({step.tick, step.stop, step.enable}))
    else $error("more than one control step");

endmodule
`default_nettype wire

// ===== design/averaged_hysteresis_pump_control_unit.sv =====
`default_nettype none
// Channel  Direction  Signals
// in       request    in_valid / in_stall : in_req_type, in_adc_word, in_command_byte
// out      result     out_valid / out_stall : out_pump_on, out_report_valid,
//                     out_report_mean, out_control_enabled
// cfg      write      cfg_wr_en, cfg_index, cfg_wdata
//
// One request per cycle while out_stall is low; a taken request goes into the input register,
// then through one pass of update logic into the output register, which presents its result.
// The reciprocal multiply for the block mean sits between the sum and mean registers.
// Synchronous active-low reset; no clearing pass.
// out_stall holds the output register, which backs up into the input register and
// then raises in_stall.
module averaged_hysteresis_pump_control_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ahpc_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [ahpc_pkg::ADC_W-1:0]      in_adc_word,
  input  wire logic [ahpc_pkg::CMD_W-1:0]      in_command_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_pump_on,
  output logic                                 out_report_valid,
  output logic [ahpc_pkg::VAL_W-1:0]           out_report_mean,
  output logic                                 out_control_enabled,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ahpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ahpc_pkg::VAL_W-1:0]      cfg_wdata
);
  import ahpc_pkg::*;

  logic             hold_r, hold_nxt;
  logic [REQ_W-1:0] req_r;
  logic [VAL_W-1:0] adc_val_r;
  logic [CMD_W-1:0] cmd_r;
  logic             in_take, advance;

  logic             out_valid_r, out_valid_nxt;
  logic             pump_r, report_r, enabled_r;
  logic [VAL_W-1:0] mean_out_r;

  logic             sample_en;
  logic [VAL_W-1:0] block_mean;
  ctl_step_t        step;
  ctl_stat_t        stat;

  assign advance  = hold_r && (!out_valid_r || !out_stall);
  assign in_stall = hold_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    sample_en   = 1'b0;
    step        = '0;
    if (advance) begin
      case (req_r)
        REQ_SAMPLE:  sample_en = 1'b1;
        REQ_COMMAND: begin
          step.stop   = (cmd_r == CMD_STOP);
          step.enable = (cmd_r == CMD_ENABLE);
        end
        REQ_TICK:    step.tick = 1'b1;
        default: ;
      endcase
    end
  end

  ahpc_avg u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_en  (sample_en),
    .sample_val (adc_val_r),
    .block_mean (block_mean)
  );

  ahpc_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .mean      (block_mean),
    .stat      (stat)
  );

  always_comb begin
    hold_nxt = hold_r;
    if (in_take)
      hold_nxt = 1'b1;
    else if (advance)
      hold_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)
      out_valid_nxt = 1'b1;
    else if (!out_stall)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r     <= in_req_type;
      adc_val_r <= in_adc_word[ADC_LSB +: VAL_W];
      cmd_r     <= in_command_byte;
    end
    if (advance) begin
      pump_r     <= stat.pump_on;
      enabled_r  <= stat.enabled;
      report_r   <= step.tick;
      mean_out_r <= step.tick ? block_mean : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pump_on         = pump_r;
  assign out_report_valid    = report_r;
  assign out_report_mean     = mean_out_r;
  assign out_control_enabled = enabled_r;

  a_mean_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !report_r |-> mean_out_r == '0)
    else $error("mean shown on a non-tick result");
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> hold_r && out_valid_r && out_stall)
    else $error("input stalled without a backed-up pipe");
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request lost");
  a_disabled_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !enabled_r |-> !pump_r)
    else $error("pump shown on with control disabled");

endmodule
`default_nettype wire
